// ----- hdl/sfcs_pkg.sv -----
// sfcs_pkg: shared types and constants of the spi flash command sequencer
// command codes, flash opcodes, queued job and output frame types
// no dependencies
package sfcs_pkg;

  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_READ   = 3'd1;
  localparam logic [2:0] CMD_CHIP   = 3'd2;
  localparam logic [2:0] CMD_BLOCK  = 3'd3;
  localparam logic [2:0] CMD_SECTOR = 3'd4;
  localparam logic [2:0] CMD_REPLY  = 3'd5;

  localparam logic [7:0] OP_STATUS = 8'h05;
  localparam logic [7:0] OP_WREN   = 8'h06;
  localparam logic [7:0] OP_PROG   = 8'h02;
  localparam logic [7:0] OP_READ   = 8'h03;
  localparam logic [7:0] OP_SECTOR = 8'h20;
  localparam logic [7:0] OP_BLOCK  = 8'hD8;
  localparam logic [7:0] OP_CHIP   = 8'hC7;
  localparam logic [7:0] ST_BUSY   = 8'h01;

  localparam int unsigned CountW = 5;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_POLL,
    PH_COLLECT
  } phase_e;

  typedef enum logic [2:0] {
    JOB_POLL,
    JOB_CHIP,
    JOB_ERASE,
    JOB_WRITE,
    JOB_READ,
    JOB_DONE
  } job_kind_e;

  typedef struct packed {
    job_kind_e     kind;
    logic [7:0]    opcode;
    logic [23:0]   addr;
    logic [127:0]  data;
  } job_t;

  typedef struct packed {
    logic          spi_valid;
    logic [7:0]    spi_byte;
    logic          cs_begin;
    logic          cs_end;
    logic          read_slot;
    logic          host_done;
    logic [127:0]  read_data;
    logic          last;
  } frame_t;

endpackage

// ----- hdl/sfcs_front.sv -----
// sfcs_front: accepts transactions, tracks operation phase and builds jobs
// holds pending address, write burst and collected read bytes
// depends on sfcs_pkg
module sfcs_front #(
  parameter int BURST_BYTES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [2:0]          cmd_i,
  input  logic [23:0]         address_i,
  input  logic [63:0]         data_low_i,
  input  logic [63:0]         data_high_i,
  input  logic [7:0]          reply_byte_i,
  output logic                push_o,
  output sfcs_pkg::job_t      job_o
);

  sfcs_pkg::phase_e                phase_q, phase_d;
  logic                            pend_write_q, pend_write_d;
  logic [23:0]                     addr_q, addr_d;
  logic [127:0]                    wbytes_q, wbytes_d;
  logic [7:0]                      rbytes_q [16];
  logic [sfcs_pkg::CountW-1:0]     rcount_q, rcount_d;
  logic [sfcs_pkg::CountW-1:0]     rcount_inc;
  logic                            rbyte_we;
  logic [127:0]                    packed_rd;

  assign rcount_inc = rcount_q + sfcs_pkg::CountW'(1);

  // read data with the incoming byte merged in, bytes past the burst zeroed
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      if (k >= BURST_BYTES) begin
        packed_rd[8*k +: 8] = 8'h00;
      end else if (rcount_q[3:0] == 4'(k)) begin
        packed_rd[8*k +: 8] = reply_byte_i;
      end else begin
        packed_rd[8*k +: 8] = rbytes_q[k];
      end
    end
  end

  always_comb begin
    phase_d      = phase_q;
    pend_write_d = pend_write_q;
    addr_d       = addr_q;
    wbytes_d     = wbytes_q;
    rcount_d     = rcount_q;
    rbyte_we     = 1'b0;
    push_o       = 1'b0;
    job_o.kind   = sfcs_pkg::JOB_POLL;
    job_o.opcode = sfcs_pkg::OP_STATUS;
    job_o.addr   = addr_q;
    job_o.data   = wbytes_q;
    if (accept_i) begin
      unique case (phase_q)
        sfcs_pkg::PH_POLL: begin
          if (cmd_i == sfcs_pkg::CMD_REPLY) begin
            push_o = 1'b1;
            if ((reply_byte_i & sfcs_pkg::ST_BUSY) != 8'h00) begin
              job_o.kind = sfcs_pkg::JOB_POLL;
            end else if (pend_write_q) begin
              job_o.kind = sfcs_pkg::JOB_WRITE;
              phase_d    = sfcs_pkg::PH_IDLE;
            end else begin
              job_o.kind = sfcs_pkg::JOB_READ;
              rcount_d   = '0;
              phase_d    = sfcs_pkg::PH_COLLECT;
            end
          end
        end
        sfcs_pkg::PH_COLLECT: begin
          if (cmd_i == sfcs_pkg::CMD_REPLY) begin
            rbyte_we = 1'b1;
            if (rcount_inc >= sfcs_pkg::CountW'(BURST_BYTES)) begin
              push_o     = 1'b1;
              job_o.kind = sfcs_pkg::JOB_DONE;
              job_o.data = packed_rd;
              rcount_d   = '0;
              phase_d    = sfcs_pkg::PH_IDLE;
            end else begin
              rcount_d = rcount_inc;
            end
          end
        end
        default: begin
          job_o.addr = address_i;
          unique case (cmd_i) inside
            sfcs_pkg::CMD_WRITE, sfcs_pkg::CMD_READ: begin
              push_o       = 1'b1;
              job_o.kind   = sfcs_pkg::JOB_POLL;
              pend_write_d = (cmd_i == sfcs_pkg::CMD_WRITE);
              addr_d       = address_i;
              phase_d      = sfcs_pkg::PH_POLL;
              if (cmd_i == sfcs_pkg::CMD_WRITE) begin
                wbytes_d = {data_high_i, data_low_i};
              end
            end
            sfcs_pkg::CMD_CHIP: begin
              push_o       = 1'b1;
              job_o.kind   = sfcs_pkg::JOB_CHIP;
              pend_write_d = 1'b0;
              addr_d       = address_i;
            end
            sfcs_pkg::CMD_BLOCK, sfcs_pkg::CMD_SECTOR: begin
              push_o       = 1'b1;
              job_o.kind   = sfcs_pkg::JOB_ERASE;
              job_o.opcode = (cmd_i == sfcs_pkg::CMD_BLOCK) ? sfcs_pkg::OP_BLOCK
                                                             : sfcs_pkg::OP_SECTOR;
              pend_write_d = 1'b0;
              addr_d       = address_i;
            end
            default: begin
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= sfcs_pkg::PH_IDLE;
      pend_write_q <= 1'b0;
      addr_q       <= '0;
      rcount_q     <= '0;
    end else begin
      phase_q      <= phase_d;
      pend_write_q <= pend_write_d;
      addr_q       <= addr_d;
      rcount_q     <= rcount_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wbytes_q <= wbytes_d;
    if (rbyte_we) begin
      rbytes_q[rcount_q[3:0]] <= reply_byte_i;
    end
  end

endmodule

// ----- hdl/sfcs_queue.sv -----
// sfcs_queue: two-entry job queue between front and back
// depends on sfcs_pkg
module sfcs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sfcs_pkg::job_t    push_job_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              head_valid_o,
  output sfcs_pkg::job_t    head_o
);

  sfcs_pkg::job_t  mem_q [sfcs_pkg::QDepth];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;

  assign full_o       = (count_q == 2'(sfcs_pkg::QDepth));
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ----- hdl/sfcs_back.sv -----
// sfcs_back: expands queued jobs into spi byte frames, one per unstalled cycle
// registered output frame; depends on sfcs_pkg
module sfcs_back #(
  parameter int BURST_BYTES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  sfcs_pkg::job_t    head_i,
  output logic              pop_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output sfcs_pkg::frame_t  frame_o
);

  logic [sfcs_pkg::CountW-1:0]  idx_q, idx_d;
  logic [sfcs_pkg::CountW-1:0]  wr_j, rd_j;
  logic                         out_valid_q, out_valid_d;
  sfcs_pkg::frame_t             frame_q, fr;
  logic                         adv;
  logic [7:0]                   data_byte;

  assign adv       = head_valid_i && (!out_valid_q || !out_stall_i);
  assign wr_j      = idx_q - sfcs_pkg::CountW'(5);
  assign rd_j      = idx_q - sfcs_pkg::CountW'(4);
  assign data_byte = head_i.data[{wr_j[3:0], 3'b000} +: 8];

  always_comb begin
    fr           = '0;
    fr.spi_valid = 1'b1;
    unique case (head_i.kind)
      sfcs_pkg::JOB_POLL: begin
        if (idx_q == '0) begin
          fr.spi_byte = sfcs_pkg::OP_STATUS;
          fr.cs_begin = 1'b1;
        end else begin
          fr.cs_end    = 1'b1;
          fr.read_slot = 1'b1;
          fr.last      = 1'b1;
        end
      end
      sfcs_pkg::JOB_CHIP: begin
        fr.cs_begin = 1'b1;
        fr.cs_end   = 1'b1;
        if (idx_q == '0) begin
          fr.spi_byte = sfcs_pkg::OP_WREN;
        end else begin
          fr.spi_byte  = sfcs_pkg::OP_CHIP;
          fr.host_done = 1'b1;
          fr.last      = 1'b1;
        end
      end
      sfcs_pkg::JOB_ERASE: begin
        case (idx_q)
          5'd0: begin
            fr.spi_byte = sfcs_pkg::OP_WREN;
            fr.cs_begin = 1'b1;
            fr.cs_end   = 1'b1;
          end
          5'd1: begin
            fr.spi_byte = head_i.opcode;
            fr.cs_begin = 1'b1;
          end
          5'd2: fr.spi_byte = head_i.addr[23:16];
          5'd3: fr.spi_byte = head_i.addr[15:8];
          default: begin
            fr.cs_end    = 1'b1;
            fr.host_done = 1'b1;
            fr.last      = 1'b1;
          end
        endcase
      end
      sfcs_pkg::JOB_WRITE: begin
        case (idx_q)
          5'd0: begin
            fr.spi_byte = sfcs_pkg::OP_WREN;
            fr.cs_begin = 1'b1;
            fr.cs_end   = 1'b1;
          end
          5'd1: begin
            fr.spi_byte = sfcs_pkg::OP_PROG;
            fr.cs_begin = 1'b1;
          end
          5'd2: fr.spi_byte = head_i.addr[23:16];
          5'd3: fr.spi_byte = head_i.addr[15:8];
          5'd4: fr.spi_byte = head_i.addr[7:0];
          default: begin
            fr.spi_byte = data_byte;
            if (wr_j == sfcs_pkg::CountW'(BURST_BYTES - 1)) begin
              fr.cs_end    = 1'b1;
              fr.host_done = 1'b1;
              fr.last      = 1'b1;
            end
          end
        endcase
      end
      sfcs_pkg::JOB_READ: begin
        case (idx_q)
          5'd0: begin
            fr.spi_byte = sfcs_pkg::OP_READ;
            fr.cs_begin = 1'b1;
          end
          5'd1: fr.spi_byte = head_i.addr[23:16];
          5'd2: fr.spi_byte = head_i.addr[15:8];
          5'd3: fr.spi_byte = head_i.addr[7:0];
          default: begin
            fr.read_slot = 1'b1;
            if (rd_j == sfcs_pkg::CountW'(BURST_BYTES - 1)) begin
              fr.cs_end = 1'b1;
              fr.last   = 1'b1;
            end
          end
        endcase
      end
      default: begin
        fr.spi_valid = 1'b0;
        fr.host_done = 1'b1;
        fr.read_data = head_i.data;
        fr.last      = 1'b1;
      end
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;
    if (adv) begin
      out_valid_d = 1'b1;
      if (fr.last) begin
        pop_o = 1'b1;
        idx_d = '0;
      end else begin
        idx_d = idx_q + sfcs_pkg::CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      frame_q <= fr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign frame_o     = frame_q;

endmodule

// ----- hdl/spi_flash_command_sequencer.sv -----
// spi_flash_command_sequencer: top level of the spi flash command sequencer
// front classifier, two-entry job queue and frame generator
// depends on sfcs_pkg, sfcs_front, sfcs_queue, sfcs_back
//
// input channel: in_valid_i / in_stall_o carry one command or flash reply per
// transaction (cmd, address, write burst, reply byte). output channel:
// out_valid_o / out_stall_i carry one spi byte frame or host-done result per
// transaction; last_of_run_o marks the final result of one input transaction.
// the front takes one input transaction per cycle while the queue is not
// full and updates the operation state at once; every transaction that
// produces results queues one job. the back turns the head job into frames,
// one per cycle while the output is not stalled, into an output register; a
// result passes through a queue entry, then the output register. the frame
// generator sets the sustained rate; in_stall_o rises only when two jobs wait
// in the queue. while out_stall_i is high a valid output frame holds and the
// queue fills behind it. reset clears the phase to idle, the read counter,
// the queue and the output valid; burst data is not reset.
module spi_flash_command_sequencer #(
  parameter int BURST_BYTES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [2:0]    cmd_i,
  input  logic [23:0]   address_i,
  input  logic [63:0]   data_low_i,
  input  logic [63:0]   data_high_i,
  input  logic [7:0]    reply_byte_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          spi_valid_o,
  output logic [7:0]    spi_byte_o,
  output logic          cs_begin_o,
  output logic          cs_end_o,
  output logic          read_slot_o,
  output logic          host_done_o,
  output logic [63:0]   read_low_o,
  output logic [63:0]   read_high_o,
  output logic          last_of_run_o
);

  logic              accept;
  logic              push;
  sfcs_pkg::job_t    push_job;
  logic              q_full;
  logic              head_valid;
  sfcs_pkg::job_t    head;
  logic              pop;
  sfcs_pkg::frame_t  frame;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  sfcs_front #(
    .BURST_BYTES (BURST_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (cmd_i),
    .address_i    (address_i),
    .data_low_i   (data_low_i),
    .data_high_i  (data_high_i),
    .reply_byte_i (reply_byte_i),
    .push_o       (push),
    .job_o        (push_job)
  );

  sfcs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  sfcs_back #(
    .BURST_BYTES (BURST_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .frame_o      (frame)
  );

  assign spi_valid_o   = frame.spi_valid;
  assign spi_byte_o    = frame.spi_byte;
  assign cs_begin_o    = frame.cs_begin;
  assign cs_end_o      = frame.cs_end;
  assign read_slot_o   = frame.read_slot;
  assign host_done_o   = frame.host_done;
  assign read_low_o    = frame.read_data[63:0];
  assign read_high_o   = frame.read_data[127:64];
  assign last_of_run_o = frame.last;

  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && host_done_o |-> last_of_run_o)
    else $error("host done without end of run");

  a_read_slot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_slot_o |-> spi_valid_o && spi_byte_o == 8'h00 && !cs_begin_o)
    else $error("read slot carries data or starts a frame");

  a_non_frame_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !spi_valid_o |-> host_done_o && last_of_run_o)
    else $error("non-frame result is not a read completion");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("job popped from empty queue");

endmodule

// ----- dv/spi_flash_command_sequencer_test.sv -----
`timescale 1ns / 100ps
// spi_flash_command_sequencer_test: self-checking testbench of the spi flash command sequencer
// drives commands and flash replies, predicts every spi frame and host-done result
// depends on sfcs_pkg and spi_flash_command_sequencer

typedef struct packed {
  logic         spi_valid;
  logic [7:0]   spi_byte;
  logic         cs_begin;
  logic         cs_end;
  logic         read_slot;
  logic         host_done;
  logic [63:0]  read_low;
  logic [63:0]  read_high;
  logic         last;
} flash_result_t;

class flash_result_scoreboard;
  int               burst;
  sfcs_pkg::phase_e phase;
  logic [2:0]       pending_op;
  logic [23:0]      target_addr;
  logic [7:0]       write_bytes [16];
  logic [7:0]       read_bytes [16];
  logic [4:0]       read_count;
  flash_result_t    run_results [$];
  flash_result_t    expected_results [$];
  int               mismatches;
  int               effective_inputs;

  function new(int burst_bytes);
    burst = burst_bytes;
    phase = sfcs_pkg::PH_IDLE;
    pending_op = '0;
    target_addr = '0;
    read_count = '0;
    mismatches = 0;
    effective_inputs = 0;
  endfunction

  function void add_frame(logic [7:0] value, logic csb, logic cse, logic slot, logic done);
    flash_result_t r;
    r = '0;
    r.spi_valid = 1'b1;
    r.spi_byte = value;
    r.cs_begin = csb;
    r.cs_end = cse;
    r.read_slot = slot;
    r.host_done = done;
    run_results.push_back(r);
  endfunction

  function void add_address(logic zero_low, logic cse_last);
    add_frame(target_addr[23:16], 1'b0, 1'b0, 1'b0, 1'b0);
    add_frame(target_addr[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
    add_frame(zero_low ? 8'h00 : target_addr[7:0], 1'b0, cse_last, 1'b0, cse_last);
  endfunction

  function void add_status_poll();
    add_frame(sfcs_pkg::OP_STATUS, 1'b1, 1'b0, 1'b0, 1'b0);
    add_frame(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
  endfunction

  function logic [63:0] pack_read(int base);
    logic [63:0] v;
    int j;
    v = '0;
    for (j = 0; j < 8; j++) begin
      if (base + j < burst && base + j < 16) v[8*j +: 8] = read_bytes[base + j];
    end
    return v;
  endfunction

  function void note_input(logic [2:0] cmd, logic [23:0] addr, logic [63:0] lo,
                           logic [63:0] hi, logic [7:0] reply);
    flash_result_t r;
    int j;
    run_results.delete();
    if (phase != sfcs_pkg::PH_POLL && phase != sfcs_pkg::PH_COLLECT) begin
      if (cmd <= sfcs_pkg::CMD_SECTOR) begin
        effective_inputs++;
        pending_op = cmd;
        target_addr = addr;
        if (cmd == sfcs_pkg::CMD_WRITE) begin
          for (j = 0; j < 8; j++) begin
            write_bytes[j] = lo[8*j +: 8];
            write_bytes[j+8] = hi[8*j +: 8];
          end
        end
        if (cmd == sfcs_pkg::CMD_WRITE || cmd == sfcs_pkg::CMD_READ) begin
          add_status_poll();
          phase = sfcs_pkg::PH_POLL;
        end else begin
          add_frame(sfcs_pkg::OP_WREN, 1'b1, 1'b1, 1'b0, 1'b0);
          if (cmd == sfcs_pkg::CMD_CHIP) begin
            add_frame(sfcs_pkg::OP_CHIP, 1'b1, 1'b1, 1'b0, 1'b1);
          end else begin
            add_frame(cmd == sfcs_pkg::CMD_BLOCK ? sfcs_pkg::OP_BLOCK : sfcs_pkg::OP_SECTOR,
                      1'b1, 1'b0, 1'b0, 1'b0);
            add_address(1'b1, 1'b1);
          end
          phase = sfcs_pkg::PH_IDLE;
        end
      end
    end else if (cmd == sfcs_pkg::CMD_REPLY) begin
      effective_inputs++;
      if (phase == sfcs_pkg::PH_POLL) begin
        if ((reply & sfcs_pkg::ST_BUSY) != 8'h00) begin
          add_status_poll();
        end else if (pending_op == sfcs_pkg::CMD_WRITE) begin
          add_frame(sfcs_pkg::OP_WREN, 1'b1, 1'b1, 1'b0, 1'b0);
          add_frame(sfcs_pkg::OP_PROG, 1'b1, 1'b0, 1'b0, 1'b0);
          add_address(1'b0, 1'b0);
          for (j = 0; j < burst && j < 16; j++) begin
            add_frame(write_bytes[j], 1'b0, j == burst - 1, 1'b0, j == burst - 1);
          end
          phase = sfcs_pkg::PH_IDLE;
        end else begin
          add_frame(sfcs_pkg::OP_READ, 1'b1, 1'b0, 1'b0, 1'b0);
          add_address(1'b0, 1'b0);
          for (j = 0; j < burst && j < 16; j++) begin
            add_frame(8'h00, 1'b0, j == burst - 1, 1'b1, 1'b0);
          end
          read_count = '0;
          phase = sfcs_pkg::PH_COLLECT;
        end
      end else begin
        read_bytes[read_count[3:0]] = reply;
        read_count = read_count + 5'd1;
        if (read_count >= burst) begin
          r = '0;
          r.host_done = 1'b1;
          r.read_low = pack_read(0);
          r.read_high = pack_read(8);
          run_results.push_back(r);
          read_count = '0;
          phase = sfcs_pkg::PH_IDLE;
        end
      end
    end
    if (run_results.size() > 0) begin
      r = run_results.pop_back();
      r.last = 1'b1;
      run_results.push_back(r);
      while (run_results.size() > 0) expected_results.push_back(run_results.pop_front());
    end
  endfunction

  function string frame_text(flash_result_t f);
    return {$sformatf("spi %0b byte %02h csb %0b cse %0b slot %0b",
                      f.spi_valid, f.spi_byte, f.cs_begin, f.cs_end, f.read_slot),
            $sformatf(" done %0b low %016h high %016h last %0b",
                      f.host_done, f.read_low, f.read_high, f.last)};
  endfunction

  function void check_result(flash_result_t got);
    flash_result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: %s", frame_text(got));
    end else begin
      want = expected_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch, expected: %s", frame_text(want));
          $display("result mismatch, actual:   %s", frame_text(got));
        end
      end
    end
  endfunction
endclass

module spi_flash_command_sequencer_test;
  localparam int BurstBytes = 16;
  localparam int IdleLimit = 1000;
  localparam int SettleCycles = 40;
  localparam int ItemsPerPhase = 42;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [2:0]  cmd_i = sfcs_pkg::CMD_WRITE;
  logic [23:0] address_i = '0;
  logic [63:0] data_low_i = '0;
  logic [63:0] data_high_i = '0;
  logic [7:0]  reply_byte_i = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        spi_valid_o;
  logic [7:0]  spi_byte_o;
  logic        cs_begin_o;
  logic        cs_end_o;
  logic        read_slot_o;
  logic        host_done_o;
  logic [63:0] read_low_o;
  logic [63:0] read_high_o;
  logic        last_of_run_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  flash_result_scoreboard board = new(BurstBytes);

  spi_flash_command_sequencer #(
    .BURST_BYTES(BurstBytes)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .address_i     (address_i),
    .data_low_i    (data_low_i),
    .data_high_i   (data_high_i),
    .reply_byte_i  (reply_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .spi_valid_o   (spi_valid_o),
    .spi_byte_o    (spi_byte_o),
    .cs_begin_o    (cs_begin_o),
    .cs_end_o      (cs_end_o),
    .read_slot_o   (read_slot_o),
    .host_done_o   (host_done_o),
    .read_low_o    (read_low_o),
    .read_high_o   (read_high_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // transaction monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        board.note_input(cmd_i, address_i, data_low_i, data_high_i, reply_byte_i);
      end
      if (out_valid_o && !out_stall_i) begin
        board.check_result({spi_valid_o, spi_byte_o, cs_begin_o, cs_end_o, read_slot_o,
                            host_done_o, read_low_o, read_high_o, last_of_run_o});
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("spi_flash_command_sequencer test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [23:0] rand_addr();
    case ($urandom_range(7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom_range(24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(8'hFF));
  endfunction

  task automatic send_item(logic [2:0] cmd, logic [23:0] addr, logic [63:0] lo,
                           logic [63:0] hi, logic [7:0] reply);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    address_i <= addr;
    data_low_i <= lo;
    data_high_i <= hi;
    reply_byte_i <= reply;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_reply(logic [7:0] reply);
    send_item(sfcs_pkg::CMD_REPLY, rand_addr(), rand_word(), rand_word(), reply);
  endtask

  task automatic busy_noise(int pct);
    logic [2:0] cmd;
    if ($urandom_range(99) < pct) begin
      if ($urandom_range(1) == 0) cmd = 3'($urandom_range(sfcs_pkg::CMD_SECTOR));
      else cmd = $urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
      send_item(cmd, rand_addr(), rand_word(), rand_word(), rand_byte());
    end
  endtask

  task automatic idle_noise();
    logic [2:0] cmd;
    case ($urandom_range(2))
      0: cmd = CMD_UNUSED_LO;
      1: cmd = CMD_UNUSED_HI;
      default: cmd = sfcs_pkg::CMD_REPLY;
    endcase
    send_item(cmd, rand_addr(), rand_word(), rand_word(), rand_byte());
  endtask

  task automatic run_operation(logic [2:0] op, int busy_polls, int noise_pct);
    int i;
    send_item(op, rand_addr(), rand_word(), rand_word(), rand_byte());
    if (op == sfcs_pkg::CMD_WRITE || op == sfcs_pkg::CMD_READ) begin
      for (i = 0; i < busy_polls; i++) begin
        busy_noise(noise_pct);
        send_reply(rand_byte() | sfcs_pkg::ST_BUSY);
      end
      busy_noise(noise_pct);
      send_reply(rand_byte() & ~sfcs_pkg::ST_BUSY);
      if (op == sfcs_pkg::CMD_READ) begin
        for (i = 0; i < BurstBytes; i++) begin
          busy_noise(noise_pct);
          send_reply(rand_byte());
        end
      end
    end
  endtask

  task automatic run_directed();
    int i;
    send_reply(8'hFF);
    send_item(CMD_UNUSED_LO, 24'hFFFFFF, '1, '1, 8'hFF);
    send_item(sfcs_pkg::CMD_CHIP, 24'hFFFFFF, '1, '1, 8'hFF);
    send_item(sfcs_pkg::CMD_BLOCK, 24'hFFFFFF, '0, '0, 8'h00);
    send_item(sfcs_pkg::CMD_SECTOR, 24'h000000, '1, '0, 8'h01);
    send_item(sfcs_pkg::CMD_WRITE, 24'hFFFFFF, '1, '1, 8'h00);
    // busy status, then an unknown code and a read start while polling
    send_reply(8'hFF);
    send_item(CMD_UNUSED_HI, 24'h000000, '0, '0, 8'h00);
    send_item(sfcs_pkg::CMD_READ, 24'h000000, '0, '0, 8'hFF);
    send_reply(8'hFE);
    send_item(sfcs_pkg::CMD_READ, 24'h000000, '0, '0, 8'h00);
    send_reply(8'h00);
    for (i = 0; i < BurstBytes; i++) send_reply(i[0] ? 8'h00 : 8'hFF);
  endtask

  task automatic run_random(int target);
    int pick;
    int polls;
    while (board.effective_inputs < target) begin
      pick = $urandom_range(99);
      polls = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
      if (pick < 10) idle_noise();
      else if (pick < 40) run_operation(sfcs_pkg::CMD_WRITE, polls, 10);
      else if (pick < 62) run_operation(sfcs_pkg::CMD_READ, polls, 10);
      else if (pick < 74) run_operation(sfcs_pkg::CMD_CHIP, 0, 0);
      else if (pick < 87) run_operation(sfcs_pkg::CMD_BLOCK, 0, 0);
      else run_operation(sfcs_pkg::CMD_SECTOR, 0, 0);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    send_idle_pct = 16;
    recv_stall_pct = 62;
    run_random(board.effective_inputs + ItemsPerPhase);
    send_idle_pct = 62;
    recv_stall_pct = 16;
    run_random(board.effective_inputs + ItemsPerPhase);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(board.effective_inputs + ItemsPerPhase);
    in_valid_i <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_results.size() == 0) begin
      $display("spi_flash_command_sequencer test passed");
    end else begin
      $display("spi_flash_command_sequencer test failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hdl/sfcs_pkg.sv
hdl/sfcs_front.sv
hdl/sfcs_queue.sv
hdl/sfcs_back.sv
hdl/spi_flash_command_sequencer.sv
dv/spi_flash_command_sequencer_test.sv
